FILE: rtl/aids_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aids_pkg
// Shared widths, operation and status codes, and the result record of the
// ordered word store.
// ----------------------------------------------------------------------------
package aids_pkg;

    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd3;

    localparam logic [ST_W-1:0] STAT_OK       = 3'd0;
    localparam logic [ST_W-1:0] STAT_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [ST_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic             last;
    } aids_res_t;

endpackage

FILE: rtl/aids_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aids_out_stage
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module aids_out_stage
    import aids_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  aids_res_t         res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   status,
    output logic signed [VAL_W-1:0] value_res,
    output logic [POS_W-1:0]  position_res,
    output logic              last
);

    logic      valid_reg;
    aids_res_t res_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && free)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = res_reg.status;
    assign value_res    = res_reg.value;
    assign position_res = res_reg.position;
    assign last         = res_reg.last;

endmodule

FILE: rtl/array_insert_delete_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_search_top
// Ordered store of signed words with insert, delete, linear search and
// traversal, held in one synchronous memory.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready is high only between items. All
// work goes through a single memory with one read and one write port and a
// registered read, moving one entry per cycle, except that a traversal holds
// its read word while the output register is full. Insert at position p moves
// the words from p upward one place higher, from the top down; delete at p
// moves the words above p one place lower; search reads upward until the
// first match; traversal emits one word per cycle while out_ready stays high.
// Errors, the empty cases, an append at the word count and a delete of the
// last word move no words. A single result waits in the response state while
// the output register is still full. Results leave through a one-entry output
// register. The memory needs no clearing after reset: only entries below
// the word count are ever read.
module array_insert_delete_search_top
    import aids_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         op,
    input  logic signed [VAL_W-1:0] value,
    input  logic [POS_W-1:0]        position,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ST_W-1:0]         status,
    output logic signed [VAL_W-1:0] value_res,
    output logic [POS_W-1:0]        position_res,
    output logic                    last
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;
    localparam logic [2:0] S_SHDN = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_TRAV = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    didx_reg, didx_next;
    logic             rd_more_reg, rd_more_next;
    logic             p_reg, p_next;
    logic [ST_W-1:0]  res_status_reg, res_status_next;
    logic [POS_W-1:0] res_pos_reg, res_pos_next;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic             out_free;
    logic             out_load;
    aids_res_t        out_res;
    logic             hold_p;
    logic             data_last;
    logic             match;
    logic [CMP_W-1:0] in_pos_w, pos_w, cnt_w, idx_w;

    assign in_pos_w  = CMP_W'(position);
    assign pos_w     = CMP_W'(pos_reg);
    assign cnt_w     = CMP_W'(count_reg);
    assign idx_w     = CMP_W'(idx_reg);
    assign data_last = (didx_reg + 1'b1) == count_reg;
    assign match     = p_reg && (rd_data_reg == val_reg);
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        didx_next       = didx_reg;
        rd_more_next    = rd_more_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;
        hold_p          = 1'b0;
        out_load        = 1'b0;
        out_res.status   = res_status_reg;
        out_res.value    = '0;
        out_res.position = res_pos_reg;
        out_res.last     = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next     = value;
                    pos_next     = position;
                    res_pos_next = '0;
                    res_status_next = STAT_OK;
                    state_next   = S_RESP;
                    case (op)
                        OP_INSERT:
                        begin
                            if (in_pos_w > cnt_w)
                            begin
                                res_status_next = STAT_BADPOS;
                            end
                            else if (count_reg == CAP_CNT)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else if (in_pos_w == cnt_w)
                            begin
                                // append: no words to move
                                wr_en      = 1'b1;
                                wr_addr    = AW'(position);
                                wr_data    = value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                idx_next     = count_reg - 1'b1;
                                rd_more_next = 1'b1;
                                state_next   = S_SHUP;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else if (in_pos_w >= cnt_w)
                            begin
                                res_status_next = STAT_BADPOS;
                            end
                            else if (in_pos_w == cnt_w - 1'b1)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                idx_next     = CW'(position) + 1'b1;
                                rd_more_next = 1'b1;
                                state_next   = S_SHDN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next     = '0;
                                rd_more_next = 1'b1;
                                state_next   = S_SRCH;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next     = '0;
                                rd_more_next = 1'b1;
                                state_next   = S_TRAV;
                            end
                        end
                    endcase
                end
            end

            S_SHUP:
            begin
                // read from the top down, write each word one place higher
                if (rd_more_reg)
                begin
                    rd_en     = 1'b1;
                    didx_next = idx_reg;
                    if (idx_w == pos_w)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                if (p_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(didx_reg + 1'b1);
                    wr_data = rd_data_reg;
                end
                else if (!rd_more_reg)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = AW'(pos_reg);
                    wr_data         = val_reg;
                    count_next      = count_reg + 1'b1;
                    res_status_next = STAT_OK;
                    state_next      = S_RESP;
                end
            end

            S_SHDN:
            begin
                // read upward, write each word one place lower
                if (rd_more_reg)
                begin
                    rd_en     = 1'b1;
                    didx_next = idx_reg;
                    if ((idx_reg + 1'b1) == count_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (p_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(didx_reg - 1'b1);
                    wr_data = rd_data_reg;
                end
                else if (!rd_more_reg)
                begin
                    count_next      = count_reg - 1'b1;
                    res_status_next = STAT_OK;
                    state_next      = S_RESP;
                end
            end

            S_SRCH:
            begin
                if (match)
                begin
                    res_status_next = STAT_OK;
                    res_pos_next    = POS_W'(didx_reg);
                    state_next      = S_RESP;
                end
                else if (p_reg && data_last)
                begin
                    res_status_next = STAT_NOTFOUND;
                    state_next      = S_RESP;
                end
                else if (rd_more_reg)
                begin
                    rd_en     = 1'b1;
                    didx_next = idx_reg;
                    if ((idx_reg + 1'b1) == count_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_TRAV:
            begin
                // hold the read word while the output register is full
                hold_p           = 1'b1;
                out_load         = p_reg;
                out_res.status   = STAT_OK;
                out_res.value    = rd_data_reg;
                out_res.position = POS_W'(didx_reg);
                out_res.last     = data_last;
                if (rd_more_reg && (!p_reg || out_free))
                begin
                    rd_en     = 1'b1;
                    didx_next = idx_reg;
                    if ((idx_reg + 1'b1) == count_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (p_reg && out_free && data_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_RESP:
            begin
                out_load = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        p_next = rd_en || (hold_p && p_reg && !out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_more_reg <= 1'b0;
            p_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_more_reg <= rd_more_next;
            p_reg       <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        didx_reg       <= didx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    aids_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .res          (out_res),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_res    (value_res),
        .position_res (position_res),
        .last         (last)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("word count above capacity");

    a_count_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_RESP))
        else $error("word count changed outside the end of an insert or delete");

    a_trav_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRAV && p_reg && !out_free) |=> $stable(rd_data_reg))
        else $error("traversal word lost during output stall");

endmodule

FILE: test/tb_array_insert_delete_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_insert_delete_search_top
// Self-checking bench for the ordered word store. A directed table covers the
// empty and bad-position cases and the extreme words. Random traffic follows,
// mostly legal inserts and deletes that grow and shrink the store, plus
// searches for held words, traversals and a fill to capacity for the full-store
// cases. Every result is compared field by field against the table's
// expectation or a shadow copy of the store kept in the bench. Both handshake
// sides idle at random, and long result-side hold-offs make the block back up and stall its input.
// ----------------------------------------------------------------------------
module tb_array_insert_delete_search_top;
    import aids_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int BLOCK_ITEMS  = 30;
    localparam int NUM_BLOCKS   = 9;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_DRILLS   = 23;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

    // one row of the directed table; the expectation is used when typed is set
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic             typed;
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] found;
    } drill_row_t;

    localparam drill_row_t DRILLS [NUM_DRILLS] = '{
        '{OP_TRAVERSE, 32'h0000_0000, 6'd0,  1'b1, STAT_EMPTY,    6'd0},
        '{OP_DELETE,   32'h0000_0000, 6'd0,  1'b1, STAT_EMPTY,    6'd0},
        '{OP_SEARCH,   32'h0000_0000, 6'd63, 1'b1, STAT_EMPTY,    6'd0},
        '{OP_INSERT,   32'h0000_0005, 6'd1,  1'b1, STAT_BADPOS,   6'd0},
        '{OP_INSERT,   32'h0000_0005, 6'd63, 1'b1, STAT_BADPOS,   6'd0},
        '{OP_INSERT,   32'h7FFF_FFFF, 6'd0,  1'b1, STAT_OK,       6'd0},
        '{OP_INSERT,   32'h8000_0000, 6'd0,  1'b1, STAT_OK,       6'd0},
        '{OP_INSERT,   32'hFFFF_FFFF, 6'd2,  1'b1, STAT_OK,       6'd0},
        '{OP_INSERT,   32'h0000_0000, 6'd1,  1'b1, STAT_OK,       6'd0},
        '{OP_SEARCH,   32'hFFFF_FFFF, 6'd42, 1'b1, STAT_OK,       6'd3},
        '{OP_SEARCH,   32'h8000_0000, 6'd0,  1'b1, STAT_OK,       6'd0},
        '{OP_SEARCH,   32'h0000_0005, 6'd21, 1'b1, STAT_NOTFOUND, 6'd0},
        '{OP_TRAVERSE, 32'hFFFF_FFFF, 6'd63, 1'b0, STAT_OK,       6'd0},
        '{OP_DELETE,   32'h0000_0000, 6'd4,  1'b1, STAT_BADPOS,   6'd0},
        '{OP_DELETE,   32'h0000_0000, 6'd63, 1'b1, STAT_BADPOS,   6'd0},
        '{OP_DELETE,   32'hFFFF_FFFF, 6'd3,  1'b1, STAT_OK,       6'd0},
        '{OP_DELETE,   32'h0000_0000, 6'd0,  1'b1, STAT_OK,       6'd0},
        '{OP_INSERT,   32'h0000_0000, 6'd0,  1'b1, STAT_OK,       6'd0},
        '{OP_SEARCH,   32'h0000_0000, 6'd0,  1'b1, STAT_OK,       6'd0},
        '{OP_SEARCH,   32'h7FFF_FFFF, 6'd0,  1'b1, STAT_OK,       6'd2},
        '{OP_TRAVERSE, 32'h0000_0000, 6'd0,  1'b0, STAT_OK,       6'd0},
        '{OP_DELETE,   32'h0000_0000, 6'd1,  1'b0, STAT_OK,       6'd0},
        '{OP_TRAVERSE, 32'h0000_0000, 6'd0,  1'b0, STAT_OK,       6'd0}
    };

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         op           = OP_INSERT;
    logic signed [VAL_W-1:0] value        = '0;
    logic [POS_W-1:0]        position     = '0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_res;
    logic [POS_W-1:0]        position_res;
    logic                    last;

    // shadow of the block's store and the results still owed by it
    logic [VAL_W-1:0] shadow_words [CAPACITY];
    int               shadow_count = 0;
    aids_res_t        due_results [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    bit send_idle_on   = 1'b1;
    bit recv_idle_on   = 1'b1;
    bit hold_pending   = 1'b0;

    array_insert_delete_search_top #(
        .CAPACITY     (CAPACITY)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_res    (value_res),
        .position_res (position_res),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one operation to the shadow store and list the results it owes.
    function automatic void step_shadow(input logic [OP_W-1:0] o, input logic [VAL_W-1:0] v,
                                        input logic [POS_W-1:0] p, ref aids_res_t outs[$]);
        aids_res_t r;
        int        hit;
        r = '0;
        r.last = 1'b1;
        hit = -1;
        case (o)
            OP_INSERT:
            begin
                if (int'(p) > shadow_count)
                    r.status = STAT_BADPOS;
                else if (shadow_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    for (int i = shadow_count; i > int'(p); i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p] = v;
                    shadow_count++;
                end
            end
            OP_DELETE:
            begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else if (int'(p) >= shadow_count)
                    r.status = STAT_BADPOS;
                else
                begin
                    for (int i = int'(p); i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                end
            end
            OP_SEARCH:
            begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                        if (hit < 0 && shadow_words[i] == v)
                            hit = i;
                    if (hit < 0)
                        r.status = STAT_NOTFOUND;
                    else
                        r.position = POS_W'(hit);
                end
            end
            default:
            begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        r.value    = shadow_words[i];
                        r.position = POS_W'(i);
                        r.last     = (i + 1 == shadow_count);
                        outs.push_back(r);
                    end
                    return;
                end
            end
        endcase
        outs.push_back(r);
    endfunction

    // Offer one transaction, wait for it to be taken, and record what it owes.
    task automatic offer(input logic [OP_W-1:0] o, input logic [VAL_W-1:0] v,
                         input logic [POS_W-1:0] p, input bit typed, input aids_res_t typed_res);
        int        gap;
        aids_res_t outs [$];
        gap = send_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        position <= p;
        do
            @(posedge clk);
        while (!in_ready);
        step_shadow(o, v, p, outs);
        if (typed)
            due_results.push_back(typed_res);
        else
            foreach (outs[k])
                due_results.push_back(outs[k]);
        @(negedge clk);
    endtask

    // Draw one transaction, weighted by mix and kept mostly legal.
    task automatic draw_item(input mix_t mix, output logic [OP_W-1:0] o,
                             output logic [VAL_W-1:0] v, output logic [POS_W-1:0] p);
        int pick;
        int ins_pct;
        int del_pct;
        ins_pct = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 15 : 35;
        del_pct = (mix == MIX_GROW) ? 15 : (mix == MIX_SHRINK) ? 60 : 30;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)
            o = OP_INSERT;
        else if (pick < ins_pct + del_pct)
            o = OP_DELETE;
        else if (pick < 92)
            o = OP_SEARCH;
        else
            o = OP_TRAVERSE;

        pick = $urandom_range(0, 9);
        if (pick < 5)
            v = VAL_W'($urandom_range(0, 15) - 8);
        else if (pick < 8)
            v = $urandom;
        else if (pick == 8)
            v = 32'h7FFF_FFFF;
        else
            v = 32'h8000_0000;
        // aim most searches at a held word
        if (o == OP_SEARCH && shadow_count > 0 && $urandom_range(0, 9) < 6)
            v = shadow_words[$urandom_range(0, shadow_count - 1)];

        p = POS_W'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 85)
        begin
            if (o == OP_INSERT)
                p = POS_W'($urandom_range(0, shadow_count));
            else if (o == OP_DELETE && shadow_count > 0)
                p = POS_W'($urandom_range(0, shadow_count - 1));
        end
    endtask

    // Record a failure; print only the first few.
    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endfunction

    // result side: random or long hold-offs, check each accepted transaction
    initial
    begin : result_sink
        int        stall;
        aids_res_t want;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
                stall = recv_idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (due_results.size() == 0)
                flag_mismatch($sformatf("unexpected result status=%0d value=%0d pos=%0d last=%0b",
                                        status, value_res, position_res, last));
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status || value_res !== want.value
                    || position_res !== want.position || last !== want.last)
                    flag_mismatch($sformatf(
                        "exp status=%0d value=%0d pos=%0d last=%0b, got %0d %0d %0d %0b",
                        want.status, $signed(want.value), want.position, want.last,
                        status, value_res, position_res, last));
            end
            @(negedge clk);
        end
    end

    // watchdog: count cycles in which neither side moves a transaction
    initial
    begin : watchdog
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [OP_W-1:0]  o;
        logic [VAL_W-1:0] v;
        logic [POS_W-1:0] p;
        aids_res_t        typed_res;
        mix_t             mix;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DRILLS[i])
        begin
            typed_res = '0;
            typed_res.status   = DRILLS[i].status;
            typed_res.position = DRILLS[i].found;
            typed_res.last     = 1'b1;
            offer(DRILLS[i].op, DRILLS[i].value, DRILLS[i].position, DRILLS[i].typed,
                  typed_res);
        end

        for (int blk = 0; blk < NUM_BLOCKS; blk++)
        begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            mix = (blk == 0) ? MIX_GROW : mix_t'($urandom_range(0, 2));

            // fill to capacity, then hit the full-store corners
            if (blk == 3)
            begin
                while (shadow_count < CAPACITY)
                    offer(OP_INSERT, $urandom, POS_W'($urandom_range(0, shadow_count)),
                          1'b0, '0);
                offer(OP_INSERT, $urandom, POS_W'(CAPACITY), 1'b0, '0);
                offer(OP_INSERT, $urandom, POS_W'(CAPACITY + 1), 1'b0, '0);
                hold_pending = 1'b1;
                offer(OP_TRAVERSE, '0, '0, 1'b0, '0);
                offer(OP_SEARCH, shadow_words[CAPACITY - 1], '0, 1'b0, '0);
                offer(OP_DELETE, '0, POS_W'(CAPACITY), 1'b0, '0);
                offer(OP_DELETE, '0, POS_W'(CAPACITY - 1), 1'b0, '0);
            end

            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (blk == 6 && n == 10)
                    hold_pending = 1'b1;
                draw_item(mix, o, v, p);
                offer(o, v, p, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
